### sv/lc3_pkg.sv
// Shared types, constants and helper functions for the LC-3 instruction step core.
`default_nettype none

package lc3_pkg;

  // One input transaction.
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] load_address;
    logic [15:0] load_data;
  } item_in_t;

  // One result transaction.
  typedef struct packed {
    logic [15:0] pc_after;
    logic [15:0] instruction;
    logic [1:0]  cond_code;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
    logic        halted;
    logic        out_of_window;
  } item_out_t;

  // Action codes.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_EXEC  = 2'd2;

  // Condition codes.
  localparam logic [1:0] CC_NEG  = 2'd0;
  localparam logic [1:0] CC_ZERO = 2'd1;
  localparam logic [1:0] CC_POS  = 2'd2;

  // Opcodes.
  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  // Fixed words.
  localparam logic [15:0] MEM_BASE   = 16'h3000;
  localparam logic [15:0] RESET_WORD = 16'h7777;
  localparam logic [15:0] HALT_WORD  = 16'hF025;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_MEM1,
    ST_MEM2
  } state_t;

  // Decisions of the execute stage, passed from the ALU to the sequencer.
  typedef struct packed {
    logic [15:0] pc_next;
    logic        reg_we;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    logic        set_cc;
    logic        mem_we;
    logic        mem_rd;
    logic [15:0] mem_addr;
    logic [15:0] mem_val;
    logic        halt;
  } exec_t;

  function automatic logic [15:0] sext5(input logic [15:0] ir);
    return {{11{ir[4]}}, ir[4:0]};
  endfunction

  function automatic logic [15:0] sext6(input logic [15:0] ir);
    return {{10{ir[5]}}, ir[5:0]};
  endfunction

  function automatic logic [15:0] sext9(input logic [15:0] ir);
    return {{7{ir[8]}}, ir[8:0]};
  endfunction

  function automatic logic [15:0] sext11(input logic [15:0] ir);
    return {{5{ir[10]}}, ir[10:0]};
  endfunction

  // Condition code of a value written to a register.
  function automatic logic [1:0] cc_of(input logic [15:0] v);
    logic [1:0] c;
    if (v[15]) begin
      c = CC_NEG;
    end else if (v == 16'd0) begin
      c = CC_ZERO;
    end else begin
      c = CC_POS;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/lc3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module lc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/lc3_regfile.sv
// Eight-entry general register file: two RAM copies for two reads, valid bits for reset value.
`default_nettype none

module lc3_regfile (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        we,
  input  wire logic [2:0]  waddr,
  input  wire logic [15:0] wdata,
  input  wire logic        re,
  input  wire logic [2:0]  raddr_a,
  input  wire logic [2:0]  raddr_b,
  output logic      [15:0] rdata_a,
  output logic      [15:0] rdata_b
);
  import lc3_pkg::*;

  logic [7:0]  valid;
  logic        valid_a;
  logic        valid_b;
  logic [15:0] ram_a;
  logic [15:0] ram_b;

  // Both copies take every write so each serves one read address.
  lc3_ram #(.WIDTH(16), .DEPTH(8)) u_copy_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr_a),
    .rdata (ram_a)
  );

  lc3_ram #(.WIDTH(16), .DEPTH(8)) u_copy_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr_b),
    .rdata (ram_b)
  );

  // A register never written since reset reads as the reset word.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Valid bits are sampled together with the read so they match the data.
  always_ff @(posedge clk) begin
    if (re) begin
      valid_a <= valid[raddr_a];
      valid_b <= valid[raddr_b];
    end
  end

  assign rdata_a = valid_a ? ram_a : RESET_WORD;
  assign rdata_b = valid_b ? ram_b : RESET_WORD;

endmodule

`default_nettype wire

### sv/lc3_alu.sv
// Execute stage: decodes one instruction and computes its results and memory access.
`default_nettype none

module lc3_alu (
  input  wire logic [15:0]         ir,
  input  wire logic [15:0]         pc,
  input  wire logic [1:0]          cc,
  input  wire logic [15:0]         ra,
  input  wire logic [15:0]         rb,
  output lc3_pkg::exec_t           ex
);
  import lc3_pkg::*;

  logic [15:0] pc1;
  logic [15:0] off9;
  logic [15:0] opnd;
  logic        taken;

  // Shared address and operand terms.
  always_comb begin
    pc1   = pc + 16'd1;
    off9  = pc1 + sext9(ir);
    opnd  = ir[5] ? sext5(ir) : rb;
    taken = (ir[11] && (cc == CC_NEG)) || (ir[10] && (cc == CC_ZERO)) ||
            (ir[9] && (cc == CC_POS));
  end

  // Per-opcode decisions.
  always_comb begin
    ex          = '0;
    ex.pc_next  = pc1;
    ex.reg_idx  = ir[11:9];
    ex.mem_val  = rb;
    ex.mem_addr = off9;
    unique case (ir[15:12])
      OP_BR: begin
        if (taken) begin
          ex.pc_next = off9;
        end
      end
      OP_ADD: begin
        ex.reg_we  = 1'b1;
        ex.reg_val = ra + opnd;
        ex.set_cc  = 1'b1;
      end
      OP_LD: begin
        ex.mem_rd = 1'b1;
      end
      OP_ST: begin
        ex.mem_we = 1'b1;
      end
      OP_JSR: begin
        ex.reg_we  = 1'b1;
        ex.reg_idx = 3'd7;
        ex.reg_val = pc1;
        ex.pc_next = ir[11] ? (pc1 + sext11(ir)) : ra;
      end
      OP_AND: begin
        ex.reg_we  = 1'b1;
        ex.reg_val = ra & opnd;
        ex.set_cc  = 1'b1;
      end
      OP_LDR: begin
        ex.mem_rd   = 1'b1;
        ex.mem_addr = ra + sext6(ir);
      end
      OP_STR: begin
        ex.mem_we   = 1'b1;
        ex.mem_addr = ra + sext6(ir);
      end
      OP_NOT: begin
        ex.reg_we  = 1'b1;
        ex.reg_val = ~ra;
        ex.set_cc  = 1'b1;
      end
      OP_LDI, OP_STI: begin
        ex.mem_rd = 1'b1;
      end
      OP_JMP: begin
        ex.pc_next = ra;
      end
      OP_LEA: begin
        ex.reg_we  = 1'b1;
        ex.reg_val = off9;
      end
      OP_TRAP: begin
        ex.halt = (ir == HALT_WORD);
      end
      default: begin
        // RTI and the reserved opcode do nothing.
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/lc3_instruction_step_top.sv
// Top level of the LC-3 instruction step core: sequencer, memory window and result register.
//
//  Channel | Handshake           | Payload             | Role
//  --------+---------------------+---------------------+---------------------------------
//  in      | in_valid / in_ready | in_item (item_in_t)   | load word, start, or execute one
//  out     | out_valid/out_ready | out_item (item_out_t) | one result per input transaction
//
// Load and start finish in the decode step; BR, ADD, AND, NOT, LEA, JSR, JMP, TRAP, ST and STR
// finish in execute; LD, LDR and STI go on to MEM1, and LDI to MEM1 and MEM2. These steps follow
// the registered reads of the memory and the register file: fetch, register read, then each
// dependent memory read. After reset a clearing pass writes the reset word into every memory
// word, while in_ready stays low. A full result register stalls only the finishing step;
// the next transaction is accepted in the cycle the previous result is registered.
`default_nettype none

module lc3_instruction_step_top #(
  parameter int MEM_WORDS = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lc3_pkg::item_in_t   in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lc3_pkg::item_out_t       out_item
);
  import lc3_pkg::*;

  localparam int             AW         = $clog2(MEM_WORDS);
  localparam logic [16:0]    MemWords17 = 17'(MEM_WORDS);
  localparam logic [AW-1:0]  LastIdx    = AW'(MEM_WORDS - 1);

  // Window check and word index of an LC-3 address.
  function automatic logic in_win(input logic [15:0] a);
    logic [15:0] off;
    off = a - MEM_BASE;
    return {1'b0, off} < MemWords17;
  endfunction

  function automatic logic [AW-1:0] win_idx(input logic [15:0] a);
    logic [15:0] off;
    off = a - MEM_BASE;
    return off[AW-1:0];
  endfunction

  state_t        state;
  state_t        state_next;
  state_t        state_adv;
  logic [AW-1:0] clr_cnt;
  logic [15:0]   pc;
  logic [1:0]    cc;
  logic          halt;
  logic          oow;
  logic          oow_next;
  logic          rd_win;
  logic          fwd_hit;
  logic [15:0]   fwd_data;
  item_in_t      item;
  logic [15:0]   ir;
  exec_t         exq;
  exec_t         ex;

  logic [15:0]   mem_rdata_raw;
  logic [15:0]   mdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [15:0]   mem_raddr_lc;
  logic [AW-1:0] mem_raddr;

  logic [15:0]   rf_rdata_a;
  logic [15:0]   rf_rdata_b;
  logic          rf_re;
  logic [2:0]    rf_ra;
  logic [2:0]    rf_rb;

  logic          fin;
  logic          fire;
  logic          acc;
  logic [15:0]   pc_n;
  logic          halt_n;
  logic          rf_we;
  logic [2:0]    rf_widx;
  logic [15:0]   rf_wval;
  logic          rf_cc;
  logic          mw;
  logic [15:0]   mw_addr;
  logic [15:0]   mw_val;
  logic          res_oow;
  logic [15:0]   instr;
  logic          iss_re;
  logic [15:0]   iss_addr;
  logic          ir_load;
  logic          exq_load;
  item_out_t     res;

  // Main memory window.
  lc3_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  // General registers.
  lc3_regfile u_regs (
    .clk     (clk),
    .rst     (rst),
    .we      (fire && rf_we),
    .waddr   (rf_widx),
    .wdata   (rf_wval),
    .re      (rf_re),
    .raddr_a (rf_ra),
    .raddr_b (rf_rb),
    .rdata_a (rf_rdata_a),
    .rdata_b (rf_rdata_b)
  );

  // Execute stage decisions.
  lc3_alu u_alu (
    .ir (ir),
    .pc (pc),
    .cc (cc),
    .ra (rf_rdata_a),
    .rb (rf_rdata_b),
    .ex (ex)
  );

  // Read data seen by the sequencer: forwarded store data, zero outside the window.
  assign mdata = rd_win ? (fwd_hit ? fwd_data : mem_rdata_raw) : 16'd0;

  // Per-state work and the final commit of a transaction.
  always_comb begin
    state_adv = state;
    fin       = 1'b0;
    pc_n      = pc;
    halt_n    = halt;
    rf_we     = 1'b0;
    rf_widx   = '0;
    rf_wval   = '0;
    rf_cc     = 1'b0;
    mw        = 1'b0;
    mw_addr   = '0;
    mw_val    = '0;
    res_oow   = 1'b0;
    instr     = '0;
    oow_next  = oow;
    iss_re    = 1'b0;
    iss_addr  = pc;
    ir_load   = 1'b0;
    exq_load  = 1'b0;
    rf_re     = 1'b0;
    rf_ra     = mdata[8:6];
    rf_rb     = ((mdata[15:12] == OP_ADD) || (mdata[15:12] == OP_AND)) ?
                mdata[2:0] : mdata[11:9];
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == LastIdx) begin
          state_adv = ST_IDLE;
        end
      end
      ST_IDLE: begin
      end
      ST_DECODE: begin
        if ((item.action == ACT_EXEC) && !halt) begin
          rf_re     = 1'b1;
          ir_load   = 1'b1;
          oow_next  = !rd_win;
          state_adv = ST_EXEC;
        end else begin
          fin = 1'b1;
          if (item.action == ACT_LOAD) begin
            mw      = in_win(item.load_address);
            mw_addr = item.load_address;
            mw_val  = item.load_data;
            res_oow = !in_win(item.load_address);
          end else if (item.action == ACT_START) begin
            pc_n   = item.load_data;
            halt_n = 1'b0;
          end
        end
      end
      ST_EXEC: begin
        instr = ir;
        if (ex.mem_rd) begin
          iss_re    = 1'b1;
          iss_addr  = ex.mem_addr;
          exq_load  = 1'b1;
          state_adv = ST_MEM1;
        end else begin
          fin     = 1'b1;
          pc_n    = ex.pc_next;
          halt_n  = ex.halt;
          rf_we   = ex.reg_we;
          rf_widx = ex.reg_idx;
          rf_wval = ex.reg_val;
          rf_cc   = ex.set_cc;
          mw      = ex.mem_we && in_win(ex.mem_addr);
          mw_addr = ex.mem_addr;
          mw_val  = ex.mem_val;
          res_oow = oow || (ex.mem_we && !in_win(ex.mem_addr));
        end
      end
      ST_MEM1: begin
        instr = ir;
        pc_n  = exq.pc_next;
        if (ir[15:12] == OP_LDI) begin
          iss_re    = 1'b1;
          iss_addr  = mdata;
          oow_next  = oow || !rd_win;
          state_adv = ST_MEM2;
        end else if (ir[15:12] == OP_STI) begin
          fin     = 1'b1;
          mw      = in_win(mdata);
          mw_addr = mdata;
          mw_val  = exq.mem_val;
          res_oow = oow || !rd_win || !in_win(mdata);
        end else begin
          fin     = 1'b1;
          rf_we   = 1'b1;
          rf_widx = exq.reg_idx;
          rf_wval = mdata;
          rf_cc   = 1'b1;
          res_oow = oow || !rd_win;
        end
      end
      ST_MEM2: begin
        instr   = ir;
        pc_n    = exq.pc_next;
        fin     = 1'b1;
        rf_we   = 1'b1;
        rf_widx = exq.reg_idx;
        rf_wval = mdata;
        rf_cc   = 1'b1;
        res_oow = oow || !rd_win;
      end
      default: begin
        state_adv = ST_IDLE;
      end
    endcase
  end

  // Handshakes: a result commits when the result register is free; a new transaction
  // is taken in idle or in the cycle the previous one commits.
  assign fire     = fin && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) || fire;
  assign acc      = in_valid && in_ready;

  // Next state and the memory read port.
  always_comb begin
    mem_re       = iss_re || acc;
    mem_raddr_lc = acc ? pc_n : iss_addr;
    mem_raddr    = win_idx(mem_raddr_lc);
    if (acc) begin
      state_next = ST_DECODE;
    end else if (fire) begin
      state_next = ST_IDLE;
    end else begin
      state_next = state_adv;
    end
  end

  // Memory write port: clearing pass after reset, then committed stores and loads.
  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = RESET_WORD;
    end else begin
      mem_we    = fire && mw;
      mem_waddr = win_idx(mw_addr);
      mem_wdata = mw_val;
    end
  end

  // Result assembly.
  always_comb begin
    res               = '0;
    res.pc_after      = pc_n;
    res.instruction   = instr;
    res.cond_code     = rf_cc ? cc_of(rf_wval) : cc;
    res.reg_written   = rf_we;
    res.reg_index     = rf_we ? rf_widx : 3'd0;
    res.reg_value     = rf_we ? rf_wval : 16'd0;
    res.mem_written   = mw;
    res.mem_address   = mw ? mw_addr : 16'd0;
    res.mem_value     = mw ? mw_val : 16'd0;
    res.halted        = halt_n;
    res.out_of_window = res_oow;
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      pc        <= MEM_BASE;
      cc        <= CC_ZERO;
      halt      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (fire) begin
        pc   <= pc_n;
        halt <= halt_n;
        if (rf_cc) begin
          cc <= cc_of(rf_wval);
        end
      end
      out_valid <= fire || (out_valid && !out_ready);
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    oow <= oow_next;
    if (acc) begin
      item <= in_item;
    end
    if (fire) begin
      out_item <= res;
    end
    if (mem_re) begin
      rd_win   <= in_win(mem_raddr_lc);
      fwd_hit  <= mem_we && (mem_waddr == mem_raddr);
      fwd_data <= mem_wdata;
    end
    if (ir_load) begin
      ir <= mdata;
    end
    if (exq_load) begin
      exq <= ex;
    end
  end

  // An accepted transaction always starts in the decode step.
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state == ST_DECODE))
    else $error("accepted transaction did not enter decode");

  // A commit with no new transaction leaves the core idle.
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && !acc) |=> (state == ST_IDLE))
    else $error("core not idle after commit");

  // No instruction executes while the core is halted.
  a_exec_not_halted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !halt)
    else $error("instruction executing while halted");

  // Only LDI reaches the second memory read.
  a_mem2_ldi: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MEM2) |-> (ir[15:12] == OP_LDI))
    else $error("second memory read for an instruction other than LDI");

endmodule

`default_nettype wire
